[sv/tdttot_pkg.sv]
package tdttot_pkg;

  localparam logic [7:0] TID_TDT = 8'h70;
  localparam logic [7:0] TID_TOT = 8'h73;

  localparam int unsigned MAX_SECTION_BYTES = 4096;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  localparam logic [11:0] POS_MAX = 12'hFFF;

  typedef logic [2:0] role_t;
  localparam role_t ROLE_HEADER   = 3'd0;
  localparam role_t ROLE_UTC      = 3'd1;
  localparam role_t ROLE_LOOPLEN  = 3'd2;
  localparam role_t ROLE_TAG      = 3'd3;
  localparam role_t ROLE_DESC_LEN = 3'd4;
  localparam role_t ROLE_DATA     = 3'd5;
  localparam role_t ROLE_CRC      = 3'd6;
  localparam role_t ROLE_IGNORED  = 3'd7;

  typedef logic [2:0] verdict_t;
  localparam verdict_t V_OK      = 3'd0;
  localparam verdict_t V_TABLE   = 3'd1;
  localparam verdict_t V_TDTLEN  = 3'd2;
  localparam verdict_t V_CRC     = 3'd3;
  localparam verdict_t V_LENGTH  = 3'd4;
  localparam verdict_t V_OVERRUN = 3'd5;

  typedef logic [1:0] phase_t;
  localparam phase_t PH_TAG  = 2'd0;
  localparam phase_t PH_LEN  = 2'd1;
  localparam phase_t PH_DATA = 2'd2;
  localparam phase_t PH_SKIP = 2'd3;

endpackage

[sv/tdttot_in_if.sv]
interface tdttot_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_section;

  modport source(output valid, data_byte, end_of_section, input ready);
  modport sink(input valid, data_byte, end_of_section, output ready);
endinterface

[sv/tdttot_out_if.sv]
interface tdttot_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_role;
  logic [7:0]  byte_value;
  logic [7:0]  descriptor_index;
  logic        section_done;
  logic [2:0]  verdict;
  logic [39:0] utc_time;
  logic [7:0]  descriptor_total;

  modport source(output valid, byte_role, byte_value, descriptor_index, section_done,
                 verdict, utc_time, descriptor_total, input ready);
  modport sink(input valid, byte_role, byte_value, descriptor_index, section_done,
               verdict, utc_time, descriptor_total, output ready);
endinterface

[sv/tdttot_crc.sv]
module tdttot_crc (
  input  logic [31:0] seed,
  input  logic [7:0]  data,
  output logic [31:0] folded
);
  import tdttot_pkg::*;

  always_comb begin
    folded = seed ^ {data, 24'h000000};
    for (int k = 0; k < 8; k++) begin
      if (folded[31]) begin
        folded = {folded[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        folded = {folded[30:0], 1'b0};
      end
    end
  end
endmodule

[sv/tdt_tot_section_decoder.sv]
// An accepted input word passes through the input register, then the result register,
// to its result word. Throughput: one word per cycle, sustained under no stall;
// the CRC folds a whole byte per cycle so nothing iterates.
// Reset: synchronous, active high; clears both pipeline stages and the section state.
// After each end-of-section word the section state returns to its reset values.
module tdt_tot_section_decoder (
  input  logic               clk,
  input  logic               rst,
  tdttot_in_if.sink          byte_ch,
  tdttot_out_if.source       res_ch
);
  import tdttot_pkg::*;

  // section state
  logic [11:0] pos;
  logic [31:0] crc;
  logic        is_tot;
  logic [11:0] decl_len;
  logic [39:0] utc;
  logic [11:0] loop_len;
  logic [7:0]  remaining;
  phase_t      phase;
  logic [7:0]  count;
  verdict_t    err;

  logic [31:0] crc_next;
  logic        is_tot_next;
  logic [11:0] decl_len_next;
  logic [39:0] utc_next;
  logic [11:0] loop_len_next;
  logic [7:0]  remaining_next;
  phase_t      phase_next;
  logic [7:0]  count_next;
  verdict_t    err_next;

  // input stage
  logic        a_valid;
  logic [7:0]  a_byte;
  logic        a_eos;

  // result stage
  logic        b_valid;
  role_t       b_role;
  logic [7:0]  b_value;
  logic [7:0]  b_idx;
  logic        b_done;
  verdict_t    b_verdict;
  logic [39:0] b_utc;
  logic [7:0]  b_total;

  logic        b_free;
  logic        fire;

  logic [31:0] crc_fold;
  role_t       role;
  logic [7:0]  idx;
  verdict_t    verdict;
  logic [12:0] pos13;
  logic [12:0] last;
  logic [11:0] crc_start;
  logic [12:0] loop_end;

  assign b_free       = !b_valid || res_ch.ready;
  assign fire         = a_valid && b_free;
  assign byte_ch.ready = !a_valid || b_free;

  tdttot_crc u_crc (
    .seed   (crc),
    .data   (a_byte),
    .folded (crc_fold)
  );

  always_comb begin
    crc_next       = crc;
    is_tot_next    = is_tot;
    decl_len_next  = decl_len;
    utc_next       = utc;
    loop_len_next  = loop_len;
    remaining_next = remaining;
    phase_next     = phase;
    count_next     = count;
    err_next       = err;
    role           = ROLE_IGNORED;
    idx            = 8'd0;
    pos13          = {1'b0, pos};
    last           = {1'b0, decl_len} + 13'd2;
    crc_start      = decl_len - 12'd1;
    loop_end       = {1'b0, loop_len} + 13'd10;
    if (loop_end > {1'b0, crc_start}) begin
      loop_end = {1'b0, crc_start};
    end

    if (phase != PH_SKIP) begin
      crc_next = crc_fold;
      if (pos <= 12'd2) begin
        role = ROLE_HEADER;
        if (pos == 12'd0) begin
          is_tot_next = (a_byte == TID_TOT);
          if (a_byte != TID_TDT && a_byte != TID_TOT) begin
            if (err_next == V_OK) err_next = V_TABLE;
            phase_next = PH_SKIP;
          end
        end else if (pos == 12'd1) begin
          decl_len_next = {a_byte[3:0], 8'h00};
        end else begin
          decl_len_next = {decl_len[11:8], a_byte};
          last          = {1'b0, decl_len_next} + 13'd2;
          if (!is_tot) begin
            if (decl_len_next != 12'd5) begin
              if (err_next == V_OK) err_next = V_TDTLEN;
              phase_next = PH_SKIP;
            end
          end else if (decl_len_next < 12'd11 ||
                       {1'b0, decl_len_next} + 13'd3 > 13'(MAX_SECTION_BYTES)) begin
            if (err_next == V_OK) err_next = V_LENGTH;
            phase_next = PH_SKIP;
          end
        end
      end else if (pos <= 12'd7) begin
        role     = ROLE_UTC;
        utc_next = {utc[31:0], a_byte};
      end else if (is_tot) begin
        if (pos >= crc_start) begin
          role = ROLE_CRC;
        end else if (pos == 12'd8) begin
          role          = ROLE_LOOPLEN;
          loop_len_next = {a_byte[3:0], 8'h00};
        end else if (pos == 12'd9) begin
          role          = ROLE_LOOPLEN;
          loop_len_next = {loop_len[11:8], a_byte};
          if ({1'b0, loop_len_next} + 13'd11 > {1'b0, decl_len}) begin
            if (err_next == V_OK) err_next = V_LENGTH;
          end
        end else if (pos13 < loop_end) begin
          idx = count;
          unique case (phase)
            PH_TAG: begin
              role       = ROLE_TAG;
              phase_next = PH_LEN;
            end
            PH_LEN: begin
              role           = ROLE_DESC_LEN;
              remaining_next = a_byte;
              if (a_byte == 8'd0) begin
                if (count != 8'hFF) count_next = count + 8'd1;
                phase_next = PH_TAG;
              end else begin
                phase_next = PH_DATA;
              end
            end
            default: begin
              role           = ROLE_DATA;
              remaining_next = remaining - 8'd1;
              if (remaining_next == 8'd0) begin
                if (count != 8'hFF) count_next = count + 8'd1;
                phase_next = PH_TAG;
              end
            end
          endcase
          if (pos13 + 13'd1 == loop_end && phase_next != PH_TAG) begin
            if (err_next == V_OK) err_next = V_OVERRUN;
            phase_next = PH_TAG;
          end
        end
      end
      if (pos >= 12'd2 && pos13 == last && !a_eos && phase_next != PH_SKIP) begin
        if (err_next == V_OK) err_next = V_LENGTH;
        phase_next = PH_SKIP;
      end
    end

    verdict = err_next;
    if (verdict == V_OK && (pos < 12'd2 || pos13 != last)) begin
      verdict = V_LENGTH;
    end
    if (is_tot_next && (verdict == V_OK || verdict == V_OVERRUN) && crc_next != 32'd0) begin
      verdict = V_CRC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (byte_ch.ready) begin
      a_valid <= byte_ch.valid;
    end
    if (byte_ch.ready && byte_ch.valid) begin
      a_byte <= byte_ch.data_byte;
      a_eos  <= byte_ch.end_of_section;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
    if (fire) begin
      b_role    <= role;
      b_value   <= a_byte;
      b_idx     <= idx;
      b_done    <= a_eos;
      b_verdict <= a_eos ? verdict : V_OK;
      b_utc     <= a_eos ? utc_next : 40'd0;
      b_total   <= a_eos ? count_next : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && a_eos)) begin
      pos       <= 12'd0;
      crc       <= CRC_INIT;
      is_tot    <= 1'b0;
      decl_len  <= 12'd0;
      utc       <= 40'd0;
      loop_len  <= 12'd0;
      remaining <= 8'd0;
      phase     <= PH_TAG;
      count     <= 8'd0;
      err       <= V_OK;
    end else if (fire) begin
      if (pos != POS_MAX) pos <= pos + 12'd1;
      crc       <= crc_next;
      is_tot    <= is_tot_next;
      decl_len  <= decl_len_next;
      utc       <= utc_next;
      loop_len  <= loop_len_next;
      remaining <= remaining_next;
      phase     <= phase_next;
      count     <= count_next;
      err       <= err_next;
    end
  end

  assign res_ch.valid            = b_valid;
  assign res_ch.byte_role        = b_role;
  assign res_ch.byte_value       = b_value;
  assign res_ch.descriptor_index = b_idx;
  assign res_ch.section_done     = b_done;
  assign res_ch.verdict          = b_verdict;
  assign res_ch.utc_time         = b_utc;
  assign res_ch.descriptor_total = b_total;

`ifndef SYNTHESIS
  a_skip_has_error: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> err != V_OK)
    else $error("skip phase without a recorded error");

  a_quiet_until_done: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_done |-> b_verdict == V_OK && b_utc == 40'd0 && b_total == 8'd0)
    else $error("verdict fields set on a word that does not end the section");

  a_index_on_desc: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_idx != 8'd0 |->
      b_role == ROLE_TAG || b_role == ROLE_DESC_LEN || b_role == ROLE_DATA)
    else $error("descriptor index on a non-descriptor word");

  a_section_restart: assert property (@(posedge clk) disable iff (rst)
    fire && a_eos |=> pos == 12'd0 && crc == CRC_INIT && phase == PH_TAG)
    else $error("section state not cleared after end of section");

  a_verdict_range: assert property (@(posedge clk) disable iff (rst)
    b_valid && b_done |-> b_verdict <= V_OVERRUN)
    else $error("verdict code out of range");
`endif
endmodule
